// ----- design/jis_glyph_pixel_address_assert.svh -----
// Assertion macros used by the checker file of jis_glyph_pixel_address.
// Expects aclk and aresetn to be visible where a macro is used.
`ifndef JIS_GLYPH_PIXEL_ADDRESS_ASSERT_SVH
`define JIS_GLYPH_PIXEL_ADDRESS_ASSERT_SVH

// Same-cycle implication, off during reset.
`define JGPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("jgpa assertion failed");

// Next-cycle implication, off during reset.
`define JGPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("jgpa assertion failed");

`endif

// ----- design/jgpa_pkg.sv -----
// Package for jis_glyph_pixel_address: field widths, code constants,
// packed-layout range table, register indexes and shared types. No dependencies.
package jgpa_pkg;

    localparam int CODE_W    = 16;
    localparam int PIX_W     = 6;
    localparam int GLYPH_W   = 13;
    localparam int ADDR_W    = 22;
    localparam int BIT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam int MAX_GLYPHS_DEF      = 8192;
    localparam int MAX_GLYPH_BYTES_DEF = 512;

    localparam logic [7:0] CODE_MIN      = 8'h21;
    localparam logic [7:0] CELL_MAX      = 8'h7e;
    localparam logic [7:0] ROW_MAX       = 8'h74;
    localparam logic [7:0] LAST_ROW_CELL = 8'h24;
    localparam logic [GLYPH_W-1:0] ROW_CELLS        = 13'd94;
    localparam logic [GLYPH_W-1:0] SUBSTITUTE_GLYPH = 13'd96;

    localparam int NUM_RANGES = 12;

    typedef struct packed {
        logic [GLYPH_W-1:0] lo;
        logic [GLYPH_W-1:0] hi;
        logic [GLYPH_W-1:0] off;
    } glyph_range_t;

    localparam glyph_range_t PACKED_RANGES [NUM_RANGES] = '{
        '{13'd0,    13'd107,  13'd0},
        '{13'd203,  13'd212,  13'd56},
        '{13'd220,  13'd245,  13'd63},
        '{13'd252,  13'd277,  13'd69},
        '{13'd282,  13'd364,  13'd73},
        '{13'd376,  13'd461,  13'd84},
        '{13'd470,  13'd493,  13'd92},
        '{13'd502,  13'd525,  13'd100},
        '{13'd564,  13'd596,  13'd138},
        '{13'd612,  13'd644,  13'd153},
        '{13'd1410, 13'd4374, 13'd886},
        '{13'd4418, 13'd7805, 13'd928}
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAPPED      = 3'd0,
        CFG_GLYPH_COUNT = 3'd1,
        CFG_GLYPH_BYTES = 3'd2,
        CFG_ROW_BYTES   = 3'd3,
        CFG_WIDTH       = 3'd4,
        CFG_HEIGHT      = 3'd5
    } cfg_reg_e;

    localparam logic [12:0] RST_GLYPH_COUNT = 13'd6878;
    localparam logic [9:0]  RST_GLYPH_BYTES = 10'd32;
    localparam logic [3:0]  RST_ROW_BYTES   = 4'd2;
    localparam logic [6:0]  RST_WIDTH       = 7'd16;
    localparam logic [6:0]  RST_HEIGHT      = 7'd16;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic               subst;
        logic               in_store;
    } map_result_t;

endpackage

// ----- design/jis_glyph_pixel_address.sv -----
// Character-generator pixel address unit: top level with config registers,
// an input register and a result register. Depends on jgpa_pkg and jgpa_mapper.
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_tvalid/tready  | char_code, pixel_column, pixel_row
//  m_      | out       | m_tvalid/tready  | glyph, subst, address, bit, fault
//  cfg_    | in        | cfg_we           | cfg_addr selects, cfg_wdata
//
// One item per cycle sustained while m_tready is high; an accepted item passes the input
// register, then mapper, multiply and adds, then the result register.
// Each register advances when the one after it is empty or moving.
// A low m_tready holds the result; the input register then fills and s_tready drops.
// aresetn is synchronous; clears valids and loads register reset values.
module jis_glyph_pixel_address #(
    parameter int MAX_GLYPHS      = jgpa_pkg::MAX_GLYPHS_DEF,
    parameter int MAX_GLYPH_BYTES = jgpa_pkg::MAX_GLYPH_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] char_code, [21:16] pixel_column, [27:22] pixel_row, [31:28] zero
    input  logic [jgpa_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [12:0] glyph_number, [13] substituted, [35:14] byte_address,
    // [38:36] bit_position, [39] pixel_fault
    output logic [jgpa_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [jgpa_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [jgpa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int CW = $clog2(MAX_GLYPHS + 1);
    localparam int BW = $clog2(MAX_GLYPH_BYTES + 1);
    localparam int PW = jgpa_pkg::GLYPH_W + BW;

    // config registers
    logic        gapped_reg;
    logic [12:0] glyph_count_reg;
    logic [9:0]  glyph_bytes_reg;
    logic [3:0]  row_bytes_reg;
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gapped_reg      <= 1'b0;
            glyph_count_reg <= jgpa_pkg::RST_GLYPH_COUNT;
            glyph_bytes_reg <= jgpa_pkg::RST_GLYPH_BYTES;
            row_bytes_reg   <= jgpa_pkg::RST_ROW_BYTES;
            width_reg       <= jgpa_pkg::RST_WIDTH;
            height_reg      <= jgpa_pkg::RST_HEIGHT;
        end else if (cfg_we) begin
            case (cfg_addr)
                jgpa_pkg::CFG_GAPPED:      gapped_reg      <= cfg_wdata[0];
                jgpa_pkg::CFG_GLYPH_COUNT: glyph_count_reg <= cfg_wdata[12:0];
                jgpa_pkg::CFG_GLYPH_BYTES: glyph_bytes_reg <= cfg_wdata[9:0];
                jgpa_pkg::CFG_ROW_BYTES:   row_bytes_reg   <= cfg_wdata[3:0];
                jgpa_pkg::CFG_WIDTH:       width_reg       <= cfg_wdata[6:0];
                jgpa_pkg::CFG_HEIGHT:      height_reg      <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] count_sat;
    logic [BW-1:0] gbytes_sat;

    assign count_sat  = (CW'(glyph_count_reg) > CW'(MAX_GLYPHS)) ?
                        CW'(MAX_GLYPHS) : CW'(glyph_count_reg);
    assign gbytes_sat = (glyph_bytes_reg > 10'(MAX_GLYPH_BYTES)) ?
                        BW'(MAX_GLYPH_BYTES) : BW'(glyph_bytes_reg);

    // flow control
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_ready, s1_ready;

    assign out_ready = !out_valid_reg || m_tready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s_tready  = s1_ready;

    always_comb begin
        s1_valid_next  = s1_ready  ? s_tvalid     : s1_valid_reg;
        out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    logic [jgpa_pkg::CODE_W-1:0] s1_code_reg;
    logic [jgpa_pkg::PIX_W-1:0]  s1_col_reg;
    logic [jgpa_pkg::PIX_W-1:0]  s1_row_reg;

    always_ff @(posedge aclk) begin
        if (s1_ready && s_tvalid) begin
            s1_code_reg <= s_tdata[15:0];
            s1_col_reg  <= s_tdata[21:16];
            s1_row_reg  <= s_tdata[27:22];
        end
    end

    jgpa_pkg::map_result_t map_res;

    jgpa_mapper #(
        .MAX_GLYPHS(MAX_GLYPHS)
    ) u_mapper (
        .char_code(s1_code_reg),
        .gapped   (gapped_reg),
        .count    (count_sat),
        .result   (map_res)
    );

    logic                          fault;
    logic [PW-1:0]                 glyph_off;
    logic [9:0]                    row_off;
    logic [jgpa_pkg::ADDR_W-1:0]   addr;
    logic [jgpa_pkg::BIT_W-1:0]    bit_pos;
    logic [jgpa_pkg::OUT_DATA_W-1:0] out_data_next;
    logic [jgpa_pkg::OUT_DATA_W-1:0] out_data_reg;

    assign fault     = (7'(s1_col_reg) >= width_reg) || (7'(s1_row_reg) >= height_reg) ||
                       !map_res.in_store;
    assign glyph_off = PW'(map_res.glyph) * PW'(gbytes_sat);
    assign row_off   = 10'(s1_row_reg) * 10'(row_bytes_reg);
    assign addr      = fault ? '0 :
                       jgpa_pkg::ADDR_W'(glyph_off) + jgpa_pkg::ADDR_W'(row_off) +
                       jgpa_pkg::ADDR_W'(s1_col_reg[5:3]);
    assign bit_pos   = fault ? '0 : 3'd7 - s1_col_reg[2:0];

    assign out_data_next = {fault, bit_pos, addr, map_res.subst, map_res.glyph};

    always_ff @(posedge aclk) begin
        if (out_ready && s1_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- design/jgpa_mapper.sv -----
// Code mapper: validates a JIS row/cell code, linearizes it and, unless gapped, remaps it
// through the packed range table. Depends on jgpa_pkg.
module jgpa_mapper #(
    parameter int MAX_GLYPHS = jgpa_pkg::MAX_GLYPHS_DEF,
    localparam int CW = $clog2(MAX_GLYPHS + 1)
) (
    input  logic [jgpa_pkg::CODE_W-1:0] char_code,
    input  logic                        gapped,
    input  logic [CW-1:0]               count,
    output jgpa_pkg::map_result_t       result
);

    logic [7:0]                   hi;
    logic [7:0]                   lo;
    logic                         code_ok;
    logic [jgpa_pkg::GLYPH_W-1:0] grid;
    logic [jgpa_pkg::GLYPH_W-1:0] packed_glyph;
    logic [jgpa_pkg::NUM_RANGES-1:0] hit;
    logic [jgpa_pkg::GLYPH_W-1:0] cand;
    logic                         cand_ok;
    logic [jgpa_pkg::GLYPH_W-1:0] glyph;

    assign hi = char_code[15:8];
    assign lo = char_code[7:0];

    assign code_ok = (lo >= jgpa_pkg::CODE_MIN) && (lo <= jgpa_pkg::CELL_MAX) &&
                     (hi >= jgpa_pkg::CODE_MIN) && (hi <= jgpa_pkg::ROW_MAX) &&
                     !((hi == jgpa_pkg::ROW_MAX) && (lo > jgpa_pkg::LAST_ROW_CELL));

    assign grid = jgpa_pkg::GLYPH_W'(8'(hi - jgpa_pkg::CODE_MIN)) * jgpa_pkg::ROW_CELLS +
                  jgpa_pkg::GLYPH_W'(8'(lo - jgpa_pkg::CODE_MIN));

    // ranges are disjoint, so at most one hit
    always_comb begin
        packed_glyph = '0;
        for (int i = 0; i < jgpa_pkg::NUM_RANGES; i++) begin
            hit[i] = (grid >= jgpa_pkg::PACKED_RANGES[i].lo) &&
                     (grid <= jgpa_pkg::PACKED_RANGES[i].hi);
            if (hit[i]) begin
                packed_glyph = packed_glyph | (grid - jgpa_pkg::PACKED_RANGES[i].off);
            end
        end
    end

    assign cand    = gapped ? grid : packed_glyph;
    assign cand_ok = code_ok && (gapped || (|hit)) && (CW'(cand) < count);
    assign glyph   = cand_ok ? cand : jgpa_pkg::SUBSTITUTE_GLYPH;

    assign result.glyph    = glyph;
    assign result.subst    = !cand_ok;
    assign result.in_store = CW'(glyph) < count;

endmodule

// ----- design/jgpa_checker.sv -----
// Port-level checker for jis_glyph_pixel_address, bound to the top level.
// Depends on jgpa_pkg and jis_glyph_pixel_address_assert.svh.
`include "jis_glyph_pixel_address_assert.svh"

module jgpa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [jgpa_pkg::OUT_DATA_W-1:0] m_tdata
);

    `JGPA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `JGPA_ASSERT_IMP(a_fault_zero, m_tvalid && m_tdata[39], m_tdata[38:14] == '0)
    `JGPA_ASSERT_IMP(a_subst_glyph, m_tvalid && m_tdata[13],
                     m_tdata[12:0] == jgpa_pkg::SUBSTITUTE_GLYPH)

endmodule

bind jis_glyph_pixel_address jgpa_checker u_jgpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
